// File: rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// ple_pkg: shared types, request and status codes for the positional list engine
// depends on nothing; used by ple_cell, ple_ctrl and positional_list_engine

package ple_pkg;

	localparam int DEPTH_DEF   = 64;
	localparam int ENTRY_W_DEF = 32;
	localparam int REQ_W       = 4;
	localparam int POS_W       = 7;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 7;
	localparam int IDX_MAX_W   = 10;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 4'd0;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 4'd1;
	localparam logic [REQ_W-1:0] REQ_INS_AT    = 4'd2;
	localparam logic [REQ_W-1:0] REQ_REM_FRONT = 4'd3;
	localparam logic [REQ_W-1:0] REQ_REM_BACK  = 4'd4;
	localparam logic [REQ_W-1:0] REQ_REM_AT    = 4'd5;
	localparam logic [REQ_W-1:0] REQ_READ      = 4'd6;
	localparam logic [REQ_W-1:0] REQ_WRITE     = 4'd7;
	localparam logic [REQ_W-1:0] REQ_CLEAR     = 4'd8;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t               op;
		logic                   capture;
		logic [IDX_MAX_W-1:0]   idx;
	} cell_ctrl_t;

	// controller status toward the top level
	typedef struct packed {
		logic                   busy;
		logic                   done;
		logic                   rd_en;
		logic [STATUS_W-1:0]    status;
	} ctrl_stat_t;

	typedef struct packed {
		logic [REQ_W-1:0]       req_type;
		logic [POS_W-1:0]       position;
		logic [VALUE_W-1:0]     value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [VALUE_W-1:0]     read_value;
		logic [COUNT_W-1:0]     count;
	} rsp_t;

endpackage

// File: rtl/core/ple_cell.sv
`timescale 1ns / 1ps
// ple_cell: one storage cell of the list row plus one stage of the readout chain
// depends on ple_pkg

module ple_cell #(
	parameter int ENTRY_WIDTH = ple_pkg::ENTRY_W_DEF,
	parameter int CELL_IDX    = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ple_pkg::cell_ctrl_t     ctrl,
	input  logic [ENTRY_WIDTH-1:0]  wr_data,
	input  logic [ENTRY_WIDTH-1:0]  left_data,
	input  logic [ENTRY_WIDTH-1:0]  right_data,
	input  logic [ENTRY_WIDTH-1:0]  chain_in,
	output logic [ENTRY_WIDTH-1:0]  data,
	output logic [ENTRY_WIDTH-1:0]  chain_out
);

	localparam logic [ple_pkg::IDX_MAX_W-1:0] MY_IDX = ple_pkg::IDX_MAX_W'(CELL_IDX);

	logic [ENTRY_WIDTH-1:0] data_q;
	logic [ENTRY_WIDTH-1:0] chain_q;
	logic [ENTRY_WIDTH-1:0] data_nxt;
	logic                   here;
	logic                   above;

	assign here  = (ctrl.idx == MY_IDX);
	assign above = (MY_IDX > ctrl.idx);

	always_comb begin
		data_nxt = data_q;
		case (ctrl.op)
			ple_pkg::CELL_INSERT: begin
				if (here)
					data_nxt = wr_data;
				else if (above)
					data_nxt = left_data;
			end
			ple_pkg::CELL_REMOVE: begin
				if (here || above)
					data_nxt = right_data;
			end
			ple_pkg::CELL_WRITE: begin
				if (here)
					data_nxt = wr_data;
			end
			default: data_nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	// readout chain moves one cell a cycle toward cell 0, zero filled from the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (ctrl.capture && here) begin
			chain_q <= data_q;
		end else begin
			chain_q <= chain_in;
		end
	end

	assign data      = data_q;
	assign chain_out = chain_q;

endmodule

// File: rtl/core/ple_ctrl.sv
`timescale 1ns / 1ps
// ple_ctrl: request decode, entry count, status and readout timing
// depends on ple_pkg

module ple_ctrl #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  ple_pkg::req_t           req,
	output ple_pkg::cell_ctrl_t     cell_ctrl,
	output ple_pkg::ctrl_stat_t     stat,
	output logic [CNT_W-1:0]        count
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;

	logic [CNT_W-1:0]               count_q;
	logic [IDX_W-1:0]               wait_q;
	logic                           pend_q;
	logic                           rd_en_q;
	logic [ple_pkg::STATUS_W-1:0]   status_q;

	logic [CMP_W-1:0]               pos_c;
	logic [CMP_W-1:0]               cnt_c;
	logic [CMP_W-1:0]               tgt;
	logic                           full;
	logic                           empty;
	logic                           accept;
	logic                           busy;
	ple_pkg::cell_op_t              op;
	logic                           capture;
	logic [ple_pkg::STATUS_W-1:0]   st;
	logic [CNT_W-1:0]               cnt_nxt;

	assign pos_c  = CMP_W'(req.position);
	assign cnt_c  = CMP_W'(count_q);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign busy   = pend_q && (wait_q != '0);
	assign accept = start && !busy;

	always_comb begin
		op      = ple_pkg::CELL_HOLD;
		capture = 1'b0;
		tgt     = '0;
		st      = ple_pkg::ST_OK;
		cnt_nxt = count_q;
		case (req.req_type)
			ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK, ple_pkg::REQ_INS_AT: begin
				if (req.req_type == ple_pkg::REQ_INS_AT && pos_c > cnt_c) begin
					st = ple_pkg::ST_BADPOS;
				end else if (full) begin
					st = ple_pkg::ST_FULL;
				end else begin
					op = ple_pkg::CELL_INSERT;
					if (req.req_type == ple_pkg::REQ_INS_FRONT)
						tgt = '0;
					else if (req.req_type == ple_pkg::REQ_INS_BACK)
						tgt = cnt_c;
					else
						tgt = pos_c;
					cnt_nxt = count_q + CNT_W'(1);
				end
			end
			ple_pkg::REQ_REM_FRONT, ple_pkg::REQ_REM_BACK, ple_pkg::REQ_REM_AT: begin
				if (empty) begin
					st = ple_pkg::ST_EMPTY;
				end else if (req.req_type == ple_pkg::REQ_REM_AT && pos_c >= cnt_c) begin
					st = ple_pkg::ST_BADPOS;
				end else begin
					op      = ple_pkg::CELL_REMOVE;
					capture = 1'b1;
					if (req.req_type == ple_pkg::REQ_REM_FRONT)
						tgt = '0;
					else if (req.req_type == ple_pkg::REQ_REM_BACK)
						tgt = cnt_c - CMP_W'(1);
					else
						tgt = pos_c;
					cnt_nxt = count_q - CNT_W'(1);
				end
			end
			ple_pkg::REQ_READ, ple_pkg::REQ_WRITE: begin
				if (empty) begin
					st = ple_pkg::ST_EMPTY;
				end else if (pos_c >= cnt_c) begin
					st = ple_pkg::ST_BADPOS;
				end else if (req.req_type == ple_pkg::REQ_READ) begin
					capture = 1'b1;
					tgt     = pos_c;
				end else begin
					op  = ple_pkg::CELL_WRITE;
					tgt = pos_c;
				end
			end
			ple_pkg::REQ_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
				cnt_nxt = count_q;
			end
		endcase
	end

	always_comb begin
		cell_ctrl.op      = accept ? op : ple_pkg::CELL_HOLD;
		cell_ctrl.capture = accept && capture;
		cell_ctrl.idx     = ple_pkg::IDX_MAX_W'(tgt[IDX_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wait_q   <= '0;
			pend_q   <= 1'b0;
			rd_en_q  <= 1'b0;
			status_q <= ple_pkg::ST_OK;
		end else if (accept) begin
			count_q  <= cnt_nxt;
			wait_q   <= capture ? tgt[IDX_W-1:0] : '0;
			pend_q   <= 1'b1;
			rd_en_q  <= capture;
			status_q <= st;
		end else if (pend_q) begin
			if (wait_q != '0)
				wait_q <= wait_q - IDX_W'(1);
			else
				pend_q <= 1'b0;
		end
	end

	always_comb begin
		stat.busy   = busy;
		stat.done   = pend_q && (wait_q == '0);
		stat.rd_en  = rd_en_q;
		stat.status = status_q;
	end

	assign count = count_q;

endmodule

// File: rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps
// positional_list_engine: top level, an ordered list kept in a shifting row of cells
// depends on ple_pkg, ple_cell and ple_ctrl
// inserts, writes, clear, failed and unknown requests answer in the cycle after accept
// reads and removals at list index k answer once the entry captured at cell k reaches cell 0
// a new request is refused (busy) while a read or removal is still in the readout chain,
// which carries the picked entry one cell a cycle down to cell 0
// reset: entry count and readout chain clear at once; cell contents stay undefined,
// no clearing pass is run; the receiver cannot stall, done lasts exactly one cycle

module positional_list_engine #(
	parameter int DEPTH       = ple_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = ple_pkg::ENTRY_W_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ple_pkg::req_t   req,
	output logic            busy,
	output logic            done,
	output ple_pkg::rsp_t   rsp
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	// common widths for extending or truncating between field and entry widths
	localparam int WIDE_W = (ENTRY_WIDTH > ple_pkg::VALUE_W) ? ENTRY_WIDTH : ple_pkg::VALUE_W;
	localparam int CWID_W = (CNT_W > ple_pkg::COUNT_W) ? CNT_W : ple_pkg::COUNT_W;

	ple_pkg::cell_ctrl_t    cell_ctrl;
	ple_pkg::ctrl_stat_t    stat;
	logic [CNT_W-1:0]       count_w;

	logic [WIDE_W-1:0]      wr_wide;
	logic [ENTRY_WIDTH-1:0] wr_data;
	logic [WIDE_W-1:0]      rd_wide;
	logic [CWID_W-1:0]      cnt_wide;

	// cell i stores at cell_data[i+1]; the two ends are zero padding
	logic [ENTRY_WIDTH-1:0] cell_data [0:DEPTH+1];
	// readout chain, chain_data[DEPTH] feeds zeros into the top cell
	logic [ENTRY_WIDTH-1:0] chain_data [0:DEPTH];

	// value masked to the entry width
	assign wr_wide = WIDE_W'(req.value);
	assign wr_data = wr_wide[ENTRY_WIDTH-1:0];

	// request decode, count and result timing
	ple_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.cell_ctrl (cell_ctrl),
		.stat      (stat),
		.count     (count_w)
	);

	assign cell_data[0]       = '0;
	assign cell_data[DEPTH+1] = '0;
	assign chain_data[DEPTH]  = '0;

	// the row of cells: each takes from its left or right neighbor on a shift
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ple_cell #(
			.ENTRY_WIDTH(ENTRY_WIDTH),
			.CELL_IDX   (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.wr_data    (wr_data),
			.left_data  (cell_data[i]),
			.right_data (cell_data[i+2]),
			.chain_in   (chain_data[i+1]),
			.data       (cell_data[i+1]),
			.chain_out  (chain_data[i])
		);
	end

	// result transaction
	assign rd_wide  = WIDE_W'(chain_data[0]);
	assign cnt_wide = CWID_W'(count_w);

	always_comb begin
		rsp.status     = stat.status;
		rsp.read_value = stat.rd_en ? rd_wide[ple_pkg::VALUE_W-1:0] : '0;
		rsp.count      = cnt_wide[ple_pkg::COUNT_W-1:0];
	end

	assign busy = stat.busy;
	assign done = stat.done;

`ifndef SYNTH
	// a result never shows while the engine still refuses requests
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done asserted while busy");

	// requests without readout answer in the next cycle
	a_fast_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cell_ctrl.capture) |=> done)
		else $error("non-read transaction did not answer in one cycle");

	// the list never holds more than DEPTH entries
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_w <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	// failed transactions return no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ple_pkg::ST_OK) |-> (rsp.read_value == '0))
		else $error("failed transaction returned data");
`endif

endmodule
